>>> rtl/pip_pkg.sv
// pip_pkg: shared types and constants of the point-in-polygon test unit
// used by pip_edge_unit and point_in_polygon_test_unit; no dependencies
`timescale 1ns / 1ps

package pip_pkg;

    // table size and polygon limits
    localparam int MAX_VERTICES_DEF  = 16;
    localparam int MIN_POLY_VERTICES = 3;
    localparam int COORD_W           = 32;
    localparam int VERTEX_W          = 2 * COORD_W;

    // stream widths (input word padded to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int CNT_W  = 5;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    // operation codes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one edge job handed to the edge unit: query point, vertex i, vertex i-1
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] zi;
        logic signed [COORD_W-1:0] xj;
        logic signed [COORD_W-1:0] zj;
    } t_edge_req;

    // edge unit status back to the sequencer
    typedef struct packed {
        logic done;
        logic toggle;
    } t_edge_res;

    // edge unit phases
    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL1,
        E_MUL2,
        E_CMP
    } t_edge_phase;

    // query sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_PREV,
        S_LD_CUR,
        S_EDGE,
        S_DONE
    } t_seq_state;

endpackage

>>> rtl/pip_ram.sv
// pip_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pip_edge_unit.sv
// pip_edge_unit: exact crossing test of one polygon edge against the query point
// one shared 32x32 multiplier used twice per edge; uses pip_pkg
`timescale 1ns / 1ps

module pip_edge_unit
    import pip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_edge_req i_req,
    output t_edge_res o_res
);

    // magnitude of a 33-bit difference of two 32-bit values
    function automatic logic [COORD_W-1:0] mag33(input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] neg;
        begin
            neg = -v;
            mag33 = v[COORD_W] ? neg[COORD_W-1:0] : v[COORD_W-1:0];
        end
    endfunction

    // signed-magnitude less-than, negative zero counts as positive
    function automatic logic sm_less(input logic sa, input logic [VERTEX_W-1:0] ma,
                                     input logic sb, input logic [VERTEX_W-1:0] mb);
        logic a_neg;
        logic b_neg;
        begin
            a_neg = sa && (ma != '0);
            b_neg = sb && (mb != '0);
            if (a_neg != b_neg) begin
                sm_less = a_neg;
            end else if (!a_neg) begin
                sm_less = ma < mb;
            end else begin
                sm_less = ma > mb;
            end
        end
    endfunction

    t_edge_phase r_phase;
    t_edge_phase n_phase;

    logic signed [COORD_W:0] w_dz;
    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_ez;
    logic signed [COORD_W:0] w_ex;
    logic                    w_straddle;

    logic [COORD_W-1:0]  r_m_ex;
    logic [COORD_W-1:0]  r_m_dz;
    logic [COORD_W-1:0]  r_m_dx;
    logic [COORD_W-1:0]  r_m_ez;
    logic                r_ls;
    logic                r_rs;
    logic                r_straddle;
    logic [VERTEX_W-1:0] r_lm;
    logic [VERTEX_W-1:0] r_rm;

    logic [COORD_W-1:0]  w_mul_a;
    logic [COORD_W-1:0]  w_mul_b;
    logic [VERTEX_W-1:0] w_prod;

    // differences against vertex i, and the z straddle test
    always_comb begin
        w_dz = {i_req.zj[COORD_W-1], i_req.zj} - {i_req.zi[COORD_W-1], i_req.zi};
        w_dx = {i_req.xj[COORD_W-1], i_req.xj} - {i_req.xi[COORD_W-1], i_req.xi};
        w_ez = {i_req.pz[COORD_W-1], i_req.pz} - {i_req.zi[COORD_W-1], i_req.zi};
        w_ex = {i_req.px[COORD_W-1], i_req.px} - {i_req.xi[COORD_W-1], i_req.xi};
        w_straddle = (i_req.zi > i_req.pz) != (i_req.zj > i_req.pz);
    end

    // shared multiplier: |ex|*|dz| first, then |dx|*|ez|
    assign w_mul_a = (r_phase == E_MUL1) ? r_m_ex : r_m_dx;
    assign w_mul_b = (r_phase == E_MUL1) ? r_m_dz : r_m_ez;
    assign w_prod  = VERTEX_W'(w_mul_a) * VERTEX_W'(w_mul_b);

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m_ex     <= mag33(w_ex);
            r_m_dz     <= mag33(w_dz);
            r_m_dx     <= mag33(w_dx);
            r_m_ez     <= mag33(w_ez);
            r_ls       <= w_ex[COORD_W];
            r_rs       <= w_dx[COORD_W] ^ w_ez[COORD_W] ^ w_dz[COORD_W];
            r_straddle <= w_straddle;
        end
        if (r_phase == E_MUL1) begin
            r_lm <= w_prod;
        end
        if (r_phase == E_MUL2) begin
            r_rm <= w_prod;
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= E_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // phase sequencing and result
    always_comb begin
        n_phase      = r_phase;
        o_res.done   = 1'b0;
        o_res.toggle = 1'b0;
        case (r_phase)
            E_IDLE: begin
                if (i_req.start) begin
                    n_phase = E_MUL1;
                end
            end
            E_MUL1: n_phase = E_MUL2;
            E_MUL2: n_phase = E_CMP;
            E_CMP: begin
                o_res.done   = 1'b1;
                o_res.toggle = r_straddle && sm_less(r_ls, r_lm, r_rs, r_rm);
                n_phase      = E_IDLE;
            end
            default: n_phase = E_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_phase == E_IDLE)
        else $error("edge job started while the unit is busy");

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && r_phase == E_IDLE) |-> ##3 o_res.done)
        else $error("edge result not ready three cycles after start");

    a_toggle_needs_straddle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.toggle |-> (o_res.done && r_straddle))
        else $error("edge toggled without a z straddle");
`endif

endmodule

>>> rtl/point_in_polygon_test_unit.sv
// point_in_polygon_test_unit: even-odd point-in-polygon test over a stored vertex table
// uses pip_pkg, pip_ram and pip_edge_unit
//
// usage:
//   input stream: each word is a vertex load (tuser = 0) or a point query (tuser = 1).
//   a load writes one vertex into the table and gives no output word.
//   a query walks every edge, from the last vertex to vertex 0 and on up the
//   table, and gives one output word, bit 0 set when the point lies inside.
//   vertex_count is set over the apb port at address 0; counts above the table
//   size saturate, and under three vertices a query always answers outside.
//   each edge of a query takes a table read and then the edge unit's multiply
//   and compare phases on one shared 32x32 multiplier; a query under three
//   vertices skips the edges. the input is not ready while a query runs.
//   reset clears the vertex count, the sequencer state and the output valid
//   flag; the table holds no defined value until loaded.
//   if the output receiver stalls, the finished result waits in the output
//   register; the next load or query is still taken, and a later query holds
//   its result until that register drains.
`timescale 1ns / 1ps

module point_in_polygon_test_unit
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [3:0] vertex_index, [35:4] coord_x, [67:36] coord_z, [71:68] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] operation
    input  logic                 i_s_axis_tuser,
    // output stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] inside_res, [7:1] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);

    t_seq_state r_state;
    t_seq_state n_state;

    logic [CNT_W-1:0]          r_vertex_count;
    logic [IDXW-1:0]           r_idx;
    logic [IDXW-1:0]           n_idx;
    logic [CNTW-1:0]           r_n;
    logic [CNTW-1:0]           n_n;
    logic [CNTW-1:0]           w_n_sat;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] n_px;
    logic signed [COORD_W-1:0] r_pz;
    logic signed [COORD_W-1:0] n_pz;
    logic [VERTEX_W-1:0]       r_prev;
    logic [VERTEX_W-1:0]       n_prev;
    logic                      r_inside;
    logic                      n_inside;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_data;
    logic                      n_out_data;

    logic                      w_accept;
    logic [3:0]                w_slot;
    logic [COORD_W-1:0]        w_in_x;
    logic [COORD_W-1:0]        w_in_z;
    logic                      w_ram_we;
    logic [VERTEX_W-1:0]       w_rd;
    t_edge_req                 w_req;
    t_edge_res                 w_res;
    logic                      w_cfg_hit;

    // input word fields
    assign w_slot   = i_s_axis_tdata[3:0];
    assign w_in_x   = i_s_axis_tdata[35:4];
    assign w_in_z   = i_s_axis_tdata[67:36];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // configuration register
    assign pready    = 1'b1;
    assign w_cfg_hit = paddr[APB_AW-1:2] == REG_VERTEX_COUNT;
    assign prdata    = w_cfg_hit ? APB_DW'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (psel && penable && pwrite && pready && w_cfg_hit) begin
            r_vertex_count <= pwdata[CNT_W-1:0];
        end
    end

    // vertex count in use, saturated to the table size
    always_comb begin
        if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            w_n_sat = CNTW'(MAX_VERTICES);
        end else begin
            w_n_sat = CNTW'(r_vertex_count);
        end
    end

    // vertex table, z in the upper half; the read address follows the next index
    pip_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (IDXW'(w_slot)),
        .i_wdata ({w_in_z, w_in_x}),
        .i_raddr (n_idx),
        .o_rdata (w_rd)
    );

    // edge job: vertex i from the table read, vertex i-1 from the held copy
    always_comb begin
        w_req.px = r_px;
        w_req.pz = r_pz;
        w_req.xi = w_rd[COORD_W-1:0];
        w_req.zi = w_rd[VERTEX_W-1:COORD_W];
        w_req.xj = r_prev[COORD_W-1:0];
        w_req.zj = r_prev[VERTEX_W-1:COORD_W];
        w_req.start = (r_state == S_LD_CUR);
    end

    pip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_px       <= n_px;
        r_pz       <= n_pz;
        r_prev     <= n_prev;
        r_inside   <= n_inside;
        r_out_data <= n_out_data;
    end

    // query sequencer
    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_n             = r_n;
        n_px            = r_px;
        n_pz            = r_pz;
        n_prev          = r_prev;
        n_inside        = r_inside;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_data      = r_out_data;
        w_ram_we        = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser == OP_LOAD) begin
                        w_ram_we = 32'(w_slot) < 32'(MAX_VERTICES);
                    end else begin
                        n_px     = w_in_x;
                        n_pz     = w_in_z;
                        n_n      = w_n_sat;
                        n_inside = 1'b0;
                        if (32'(w_n_sat) < 32'(MIN_POLY_VERTICES)) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx   = IDXW'(w_n_sat - CNTW'(1));
                            n_state = S_LD_PREV;
                        end
                    end
                end
            end
            S_LD_PREV: begin
                // last vertex arrives; start reading vertex 0
                n_prev  = w_rd;
                n_idx   = '0;
                n_state = S_LD_CUR;
            end
            S_LD_CUR: begin
                n_prev  = w_rd;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (w_res.done) begin
                    if (w_res.toggle) begin
                        n_inside = !r_inside;
                    end
                    if (CNTW'(r_idx) == r_n - CNTW'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + IDXW'(1);
                        n_state = S_LD_CUR;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_inside;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_data);

`ifndef SYNTHESIS
    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("output word raised outside the done state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE || r_state == S_LD_CUR) |-> CNTW'(r_idx) < r_n)
        else $error("edge index beyond the vertex count");

    a_small_poly_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == OP_QUERY && 32'(w_n_sat) < 32'(MIN_POLY_VERTICES))
        |=> (r_state == S_DONE && !r_inside))
        else $error("query on a degenerate polygon not answered outside");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for point_in_polygon_test_unit, stream words in and out,
// vertex count over apb; expected answers come from an even-odd crossing predictor
// depends on pip_pkg and the rtl of point_in_polygon_test_unit
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 140;
    localparam int SETTLE_CYCLES = 4 * MAX_VERTICES_DEF + 16;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_LEN      = 600;
    localparam int N_DIR         = 22;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [APB_AW-1:0] ADDR_VERTEX_COUNT = APB_AW'(4 * REG_VERTEX_COUNT);

    // vertex counts of the first random phases, the rest are drawn
    localparam int PH_COUNTS [9] = '{3, 16, 0, 31, 1, 17, 8, 2, 16};

    // one directed row: optional count write, then one word
    typedef struct packed {
        logic             cfg_wr;
        logic [CNT_W-1:0] cfg_val;
        logic             op;
        logic [3:0]       slot;
        logic [31:0]      x;
        logic [31:0]      z;
        logic             typed;
        logic             typed_val;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // count 0 after reset, then an extreme square, still count 0
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'd0,        32'd0,        1'b1, 1'b0},
        '{1'b0, 5'd0, OP_LOAD,  4'd0,  C_MIN,        C_MIN,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_LOAD,  4'd1,  C_MAX,        C_MIN,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_LOAD,  4'd2,  C_MAX,        C_MAX,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_LOAD,  4'd3,  C_MIN,        C_MAX,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'd0,        32'd0,        1'b1, 1'b0},
        // two vertices is always outside
        '{1'b1, 5'd2, OP_QUERY, 4'd0,  32'd0,        32'd0,        1'b1, 1'b0},
        // full square: center inside, then edges, corners and horizontal sides
        '{1'b1, 5'd4, OP_QUERY, 4'd9,  32'd0,        32'd0,        1'b1, 1'b1},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  C_MIN,        32'd0,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  C_MAX,        32'd0,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'd0,        C_MAX,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd15, 32'd0,        C_MIN,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  C_MAX,        C_MAX,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  C_MIN,        C_MIN,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'hFFFF_FFFF, 32'd1,       1'b0, 1'b0},
        // slanted edge, points on both sides of its crossing
        '{1'b0, 5'd0, OP_LOAD,  4'd2,  32'd0,        C_MAX,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'h3FFF_FFFF, 32'd0,       1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'h4000_0000, 32'd0,       1'b0, 1'b0},
        // triangle of the first three slots
        '{1'b1, 5'd3, OP_QUERY, 4'd0,  32'd0,        32'd0,        1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'h1234_5678, 32'hEDCB_A988, 1'b0, 1'b0},
        '{1'b0, 5'd0, OP_LOAD,  4'd15, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b0},
        '{1'b0, 5'd0, OP_QUERY, 4'd0,  32'hFFFF_0000, 32'h0000_8000, 1'b0, 1'b0}
    };

    // clock, reset and block inputs
    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;

    // block outputs
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state: vertex table and count register
    logic signed [31:0] poly_x [MAX_VERTICES_DEF];
    logic signed [31:0] poly_z [MAX_VERTICES_DEF];
    logic [CNT_W-1:0]   poly_count = '0;
    bit                 expected_inside_q [$];

    int mismatches = 0;
    int rx_words   = 0;
    int hold_left  = 0;
    int snd_idle   = 31;
    int rcv_idle   = 73;

    // region that structured polygons and nearby queries gather around
    logic [31:0] focus_x = '0;
    logic [31:0] focus_z = '0;
    int unsigned focus_r = 65536;

    point_in_polygon_test_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // even-odd crossing count, exact by cross-multiplication
    function automatic bit predict_inside(input logic [31:0] qx, input logic [31:0] qz);
        int                 n;
        int                 j;
        bit                 flag;
        logic signed [31:0] px, pz, xi, zi, xj, zj;
        logic signed [33:0] dz, dx, ez, ex, adz;
        logic signed [67:0] lhs, rhs;
        px   = qx;
        pz   = qz;
        flag = 1'b0;
        n    = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
        if (n >= MIN_POLY_VERTICES) begin
            j = n - 1;
            for (int i = 0; i < n; i++) begin
                xi = poly_x[i];
                zi = poly_z[i];
                xj = poly_x[j];
                zj = poly_z[j];
                if ((zi > pz) != (zj > pz)) begin
                    dz  = zj - zi;
                    dx  = xj - xi;
                    ez  = pz - zi;
                    ex  = px - xi;
                    adz = (dz < 0) ? -dz : dz;
                    lhs = ex * adz;
                    rhs = dx * ez;
                    if (dz < 0)
                        rhs = -rhs;
                    if (lhs < rhs)
                        flag = ~flag;
                end
                j = i;
            end
        end
        return flag;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [31:0] near_focus(input logic [31:0] c);
        return c + $urandom_range(2 * focus_r) - focus_r;
    endfunction

    // vertex coordinate: full range, near the focus, or an extreme
    function automatic logic [31:0] vertex_coord(input logic [31:0] c);
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom;
        else if (r < 85)
            return near_focus(c);
        return pick_extreme();
    endfunction

    // offer one word, wait for the handshake, then update the predictor
    task automatic send_word(input logic op, input logic [3:0] slot, input logic [31:0] x,
                             input logic [31:0] z, input bit typed, input bit typed_val);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, z, x, slot};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        if (op == OP_LOAD) begin
            poly_x[slot] = x;
            poly_z[slot] = z;
        end else begin
            expected_inside_q = {expected_inside_q,
                                 (typed ? typed_val : predict_inside(x, z))};
        end
    endtask

    // wait for every answer, then let a full query run out
    task automatic wait_drained();
        while (expected_inside_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] cnt);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= APB_DW'(cnt);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        poly_count  = cnt;
    endtask

    // fresh polygon in slots 0..n-1 around a new focus
    task automatic rebuild_polygon(input int n);
        focus_x = $urandom;
        focus_z = $urandom;
        focus_r = 1 << $urandom_range(4, 24);
        for (int i = 0; i < n; i++)
            send_word(OP_LOAD, 4'(i), near_focus(focus_x), near_focus(focus_z), 1'b0, 1'b0);
    endtask

    // random query point aimed at edges, vertices and the focus region
    task automatic send_query(input int ne);
        int          r;
        int          k;
        logic [31:0] qx, qz;
        r = $urandom_range(99);
        k = (ne > 0) ? $urandom_range(ne - 1) : 0;
        if (r < 35) begin
            qx = near_focus(focus_x);
            qz = near_focus(focus_z);
        end else if (r < 55) begin
            qx = poly_x[k] + $urandom_range(2) - 1;
            qz = ($urandom_range(1) == 0) ? poly_z[k] : poly_z[$urandom_range(MAX_VERTICES_DEF - 1)];
        end else if (r < 65) begin
            qx = pick_extreme();
            qz = pick_extreme();
        end else begin
            qx = $urandom;
            qz = $urandom;
        end
        send_word(OP_QUERY, 4'($urandom), qx, qz, 1'b0, 1'b0);
    endtask

    // stimulus: directed table, slot fill, then random phases
    initial begin : stimulus
        int ne;
        int sent;
        int r;
        for (int k = 0; k < MAX_VERTICES_DEF; k++) begin
            poly_x[k] = '0;
            poly_z[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int d = 0; d < N_DIR; d++) begin
            if (DIR_ROWS[d].cfg_wr) begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_vertex_count(DIR_ROWS[d].cfg_val);
            end
            send_word(DIR_ROWS[d].op, DIR_ROWS[d].slot, DIR_ROWS[d].x, DIR_ROWS[d].z,
                      DIR_ROWS[d].typed, DIR_ROWS[d].typed_val);
        end

        // every slot holds a vertex before larger counts are used
        for (int k = 0; k < MAX_VERTICES_DEF; k++)
            send_word(OP_LOAD, 4'(k), vertex_coord(focus_x), vertex_coord(focus_z), 1'b0, 1'b0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            // idle pattern: sender light, then receiver light, then none
            case (ph * 3 / N_PHASES)
                0: begin
                    snd_idle = 31;
                    rcv_idle = 73;
                end
                1: begin
                    snd_idle = 73;
                    rcv_idle = 31;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            write_vertex_count((ph < 9) ? CNT_W'(PH_COUNTS[ph]) : CNT_W'($urandom_range(31)));
            ne   = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 6 && ne > 0) begin
                    rebuild_polygon(ne);
                    sent += ne;
                end else if (r < 30) begin
                    send_word(OP_LOAD, 4'($urandom), vertex_coord(focus_x),
                              vertex_coord(focus_z), 1'b0, 1'b0);
                    sent++;
                end else begin
                    send_query(ne);
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && expected_inside_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result side: check each word, drive tready with idling and one long hold
    always @(posedge i_clk) begin : result_side
        bit exp_val;
        bit took;
        took = i_rst_n && m_tvalid && m_tready;
        if (took) begin
            rx_words <= rx_words + 1;
            if (expected_inside_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected word %h", m_tdata);
            end else begin
                exp_val = expected_inside_q.pop_front();
                if (m_tdata !== M_TDATA_W'(exp_val)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected word %h, got %h",
                                 M_TDATA_W'(exp_val), m_tdata);
                end
            end
        end
        if (took && rx_words + 1 == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
